// ===== hdl/adp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Art-Net DMX parser package
// Shared sizes, result codes, the result struct and the small lookup
// functions used by the parser core and the top level.
// ----------------------------------------------------------------------------
package adp_pkg;

  // Datagram bytes beyond this cap are ignored.
  localparam int MAX_PACKET_BYTES = 600;
  localparam int IDX_W            = 10;
  localparam logic [IDX_W-1:0] CAP_IDX      = IDX_W'(MAX_PACKET_BYTES);
  localparam logic [IDX_W-1:0] CAP_LAST_IDX = IDX_W'(MAX_PACKET_BYTES - 1);

  // Header layout.
  localparam logic [IDX_W-1:0] HEADER_BYTES   = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_OPCODE_LO  = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_OPCODE_HI  = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_UNIV_LO    = IDX_W'(14);
  localparam logic [IDX_W-1:0] IDX_UNIV_HI    = IDX_W'(15);
  localparam logic [IDX_W-1:0] IDX_LEN_HI     = IDX_W'(16);
  localparam logic [IDX_W-1:0] IDX_LEN_LO     = IDX_W'(17);
  localparam logic [IDX_W-1:0] DATA_START     = IDX_W'(18);
  localparam logic [IDX_W-1:0] POLL_MIN_BYTES = IDX_W'(14);

  // Opcodes.
  localparam logic [15:0] OPCODE_POLL = 16'h2000;
  localparam logic [15:0] OPCODE_DMX  = 16'h5000;

  // Result item kinds.
  localparam logic [1:0] KIND_FRAME_START = 2'd0;
  localparam logic [1:0] KIND_DATA        = 2'd1;
  localparam logic [1:0] KIND_POLL_REPLY  = 2'd2;

  // Output port codes.
  localparam logic [1:0] PORT_FIRST  = 2'd0;
  localparam logic [1:0] PORT_SECOND = 2'd1;
  localparam logic [1:0] PORT_NONE   = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  port;
    logic [15:0] universe;
    logic [7:0]  out_byte;
    logic        last;
  } adp_result_t;

  // Expected signature byte: "Art-Net" followed by a zero byte.
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h41;  // A
      3'd1:    b = 8'h72;  // r
      3'd2:    b = 8'h74;  // t
      3'd3:    b = 8'h2D;  // -
      3'd4:    b = 8'h4E;  // N
      3'd5:    b = 8'h65;  // e
      3'd6:    b = 8'h74;  // t
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Universe 1 drives the first output, universe 2 the second.
  function automatic logic [1:0] port_of(input logic [15:0] uni);
    logic [1:0] p;
    priority if (uni == 16'd1) begin
      p = PORT_FIRST;
    end else if (uni == 16'd2) begin
      p = PORT_SECOND;
    end else begin
      p = PORT_NONE;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/adp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Art-Net DMX parser channel interfaces
// Valid/ready channels for datagram bytes in and parsed items out.
// ----------------------------------------------------------------------------
interface adp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface adp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [1:0]  port;
  logic [15:0] universe;
  logic [7:0]  out_byte;
  logic        last;

  modport source (output valid, output item_kind, output port, output universe,
                  output out_byte, output last, input ready);
  modport sink   (input valid, input item_kind, input port, input universe,
                  input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/artnet_dmx_packet_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Art-Net DMX packet parser
// Parses a received datagram, one byte per transaction, into DMX frame
// items and poll reply requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one datagram byte per transaction, with end_of_datagram
//   set on the final byte. out_chan carries result items: a frame start at
//   byte 17 of an ArtDmx datagram, one item per DMX data byte, and a poll
//   reply request at the end of an ArtPoll datagram. Most bytes (header,
//   ignored or capped bytes) produce no item.
//   A byte taken from in_chan is loaded into the input register; from there
//   it passes through the parse logic into the output register, which
//   drives out_chan.
//   Throughput: one byte per clock. The parse state update is a single short
//   compare-and-select step, so the input register drains every cycle that
//   the output register is free or being taken.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a datagram.
//   When the receiver stalls, the output item holds; one more byte is taken
//   into the input register, then in_chan.ready drops until out_chan moves.
// ----------------------------------------------------------------------------
module artnet_dmx_packet_parser (
  input  wire        clk,
  input  wire        rst_n,
  adp_in_if.sink     in_chan,
  adp_out_if.source  out_chan
);
  import adp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eod_r;
  logic        out_valid_r;
  adp_result_t out_item_r;

  logic        advance;
  logic        emit;
  adp_result_t result;

  // The input register moves on whenever the output register can take a result.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_eod_r  <= in_chan.end_of_datagram;
    end
  end

  adp_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .data_byte       (s1_byte_r),
    .end_of_datagram (s1_eod_r),
    .emit            (emit),
    .result          (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= result;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.item_kind = out_item_r.item_kind;
  assign out_chan.port      = out_item_r.port;
  assign out_chan.universe  = out_item_r.universe;
  assign out_chan.out_byte  = out_item_r.out_byte;
  assign out_chan.last      = out_item_r.last;

endmodule
`default_nettype wire

// ===== hdl/adp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Art-Net DMX parser core
// Holds the per-datagram parse state and decides, for each byte stepped
// through it, whether a result item is produced and what it holds.
// ----------------------------------------------------------------------------
module adp_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire [7:0]            data_byte,
  input  wire                  end_of_datagram,
  output logic                 emit,
  output adp_pkg::adp_result_t result
);
  import adp_pkg::*;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic             header_good_r, header_good_nxt;
  logic [15:0]      opcode_r, opcode_nxt;
  logic [15:0]      universe_r, universe_nxt;
  logic [15:0]      declared_length_r, declared_length_nxt;
  logic [IDX_W-1:0] data_count_r, data_count_nxt;
  logic             frame_closed_r, frame_closed_nxt;

  logic             in_range;
  logic             at_cap;
  logic             is_dmx;
  logic             end_of_frame;
  logic [IDX_W-1:0] idx_post;
  logic [IDX_W-1:0] dc_inc;

  // Decode of the current byte against the parse state.
  always_comb begin
    in_range = (byte_index_r < CAP_IDX);
    at_cap   = (byte_index_r == CAP_LAST_IDX);
    is_dmx   = header_good_r && (opcode_r == OPCODE_DMX);
    dc_inc   = data_count_r + IDX_W'(1);
    idx_post = in_range ? (byte_index_r + IDX_W'(1)) : byte_index_r;
    end_of_frame = end_of_datagram || at_cap ||
                   ((declared_length_r != 16'd0) &&
                    ({{(16-IDX_W){1'b0}}, dc_inc} == declared_length_r));

    byte_index_nxt      = byte_index_r;
    header_good_nxt     = header_good_r;
    opcode_nxt          = opcode_r;
    universe_nxt        = universe_r;
    declared_length_nxt = declared_length_r;
    data_count_nxt      = data_count_r;
    frame_closed_nxt    = frame_closed_r;

    emit               = 1'b0;
    result.item_kind   = KIND_POLL_REPLY;
    result.port        = PORT_NONE;
    result.universe    = 16'd0;
    result.out_byte    = 8'd0;
    result.last        = 1'b1;

    // Field capture and frame items for bytes inside the cap.
    if (in_range) begin
      priority if (byte_index_r < HEADER_BYTES) begin
        if (data_byte != sig_byte(byte_index_r[2:0])) begin
          header_good_nxt = 1'b0;
        end
      end else if (byte_index_r == IDX_OPCODE_LO) begin
        opcode_nxt[7:0] = data_byte;
      end else if (byte_index_r == IDX_OPCODE_HI) begin
        opcode_nxt[15:8] = data_byte;
      end else if (byte_index_r == IDX_UNIV_LO) begin
        universe_nxt[7:0] = data_byte;
      end else if (byte_index_r == IDX_UNIV_HI) begin
        universe_nxt[15:8] = data_byte;
      end else if (byte_index_r == IDX_LEN_HI) begin
        declared_length_nxt[15:8] = data_byte;
      end else if (byte_index_r == IDX_LEN_LO) begin
        declared_length_nxt[7:0] = data_byte;
        if (is_dmx) begin
          emit             = 1'b1;
          result.item_kind = KIND_FRAME_START;
          result.port      = port_of(universe_r);
          result.universe  = universe_r;
          result.out_byte  = 8'd0;
          result.last      = end_of_datagram || at_cap;
          if (end_of_datagram || at_cap) begin
            frame_closed_nxt = 1'b1;
          end
        end
      end else if (byte_index_r >= DATA_START) begin
        if (is_dmx && !frame_closed_r) begin
          emit             = 1'b1;
          result.item_kind = KIND_DATA;
          result.port      = port_of(universe_r);
          result.universe  = universe_r;
          result.out_byte  = data_byte;
          result.last      = end_of_frame;
          data_count_nxt   = dc_inc;
          if (end_of_frame) begin
            frame_closed_nxt = 1'b1;
          end
        end
      end else begin
        // Bytes 10 to 13 carry nothing this block uses.
      end
      byte_index_nxt = idx_post;
    end

    // The end of the datagram may raise a poll reply request, then clears state.
    if (end_of_datagram) begin
      if (header_good_r && (opcode_r == OPCODE_POLL) &&
          (idx_post >= POLL_MIN_BYTES) && !emit) begin
        emit             = 1'b1;
        result.item_kind = KIND_POLL_REPLY;
        result.port      = PORT_NONE;
        result.universe  = 16'd0;
        result.out_byte  = 8'd0;
        result.last      = 1'b1;
      end
      byte_index_nxt      = '0;
      header_good_nxt     = 1'b1;
      opcode_nxt          = 16'd0;
      universe_nxt        = 16'd0;
      declared_length_nxt = 16'd0;
      data_count_nxt      = '0;
      frame_closed_nxt    = 1'b0;
    end
  end

  // Parse state advances once per stepped byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r      <= '0;
      header_good_r     <= 1'b1;
      opcode_r          <= 16'd0;
      universe_r        <= 16'd0;
      declared_length_r <= 16'd0;
      data_count_r      <= '0;
      frame_closed_r    <= 1'b0;
    end else if (step) begin
      byte_index_r      <= byte_index_nxt;
      header_good_r     <= header_good_nxt;
      opcode_r          <= opcode_nxt;
      universe_r        <= universe_nxt;
      declared_length_r <= declared_length_nxt;
      data_count_r      <= data_count_nxt;
      frame_closed_r    <= frame_closed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/adp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Art-Net DMX parser port checker
// Concurrent checks on what the parser shows at its ports, bound to the
// top level.
// ----------------------------------------------------------------------------
module adp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  item_kind,
  input wire [1:0]  port,
  input wire [15:0] universe,
  input wire [7:0]  out_byte,
  input wire        last
);
  import adp_pkg::*;

  // A stalled result transaction keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(port) &&
      $stable(universe) && $stable(out_byte) && $stable(last))
    else $error("result changed while stalled");

  // A poll reply request carries fixed fields.
  a_poll_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == KIND_POLL_REPLY) |->
      (port == PORT_NONE) && last && (universe == 16'd0) && (out_byte == 8'd0))
    else $error("poll reply request fields wrong");

  // A frame start carries a zero byte.
  a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == KIND_FRAME_START) |-> (out_byte == 8'd0))
    else $error("frame start byte not zero");

  // Frame items map universe to output port.
  a_port_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((item_kind == KIND_FRAME_START) || (item_kind == KIND_DATA)) |->
      ((universe == 16'd1) == (port == PORT_FIRST)) &&
      ((universe == 16'd2) == (port == PORT_SECOND)))
    else $error("universe to port mapping wrong");

endmodule

bind artnet_dmx_packet_parser adp_checker u_adp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .item_kind (out_chan.item_kind),
  .port      (out_chan.port),
  .universe  (out_chan.universe),
  .out_byte  (out_chan.out_byte),
  .last      (out_chan.last)
);
`default_nettype wire
